@@ hdl/i2cmrr_pkg.sv @@
// shared types and constants of the i2c register-read master
`default_nettype none
package i2cmrr_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_DEV_ADDR    = 2'd0;
  localparam logic [1:0] CFG_PHASE_TICKS = 2'd1;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // reset values of the configuration registers
  localparam logic [6:0] DEV_ADDR_RST    = 7'h36;
  localparam logic [7:0] PHASE_TICKS_RST = 8'd20;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  // stream widths
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 24;

  // command kind of one request
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ1 = 2'd1,
    CMD_READ2 = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] reg_addr;
    logic       sda;
  } item_t;

  typedef struct packed {
    logic [6:0] dev_addr;
    logic [7:0] phase_ticks;
    logic [7:0] ack_timeout;
  } cfg_t;

endpackage
`default_nettype wire

@@ hdl/i2cmrr_front.sv @@
// input side: request decode and two-entry queue toward the bus sequencer
`default_nettype none
module i2cmrr_front (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   s_valid_i,
  output logic                                  s_ready_o,
  input  wire  [i2cmrr_pkg::S_TDATA_W-1:0]      s_data_i,
  input  wire  [i2cmrr_pkg::S_TUSER_W-1:0]      s_user_i,
  output logic                                  item_valid_o,
  input  wire                                   item_ready_i,
  output i2cmrr_pkg::item_t                     item_o
);
  import i2cmrr_pkg::*;

  item_t      entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  item_t      new_item;

  // unused code 3 behaves as a plain tick
  always_comb begin
    new_item.reg_addr = s_data_i[7:0];
    new_item.sda      = s_data_i[8];
    unique case (s_user_i)
      2'd1:    new_item.cmd = CMD_READ1;
      2'd2:    new_item.cmd = CMD_READ2;
      default: new_item.cmd = CMD_TICK;
    endcase
  end

  assign s_ready_o    = (count_q != 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = entry_q[rd_ptr_q];
  assign push         = s_valid_i && s_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

endmodule
`default_nettype wire

@@ hdl/i2cmrr_seq.sv @@
// back side: bus sequencer, one step per request, with registered result
`default_nettype none
module i2cmrr_seq (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               item_valid_i,
  output logic                              item_ready_o,
  input  i2cmrr_pkg::item_t                 item_i,
  input  i2cmrr_pkg::cfg_t                  cfg_i,
  output logic                              m_valid_o,
  input  wire                               m_ready_i,
  output logic [i2cmrr_pkg::M_TDATA_W-1:0]  m_data_o
);
  import i2cmrr_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_START_HI = 4'd1;
  localparam logic [3:0] ST_START_LO = 4'd2;
  localparam logic [3:0] ST_TX_SET   = 4'd3;
  localparam logic [3:0] ST_TX_HI    = 4'd4;
  localparam logic [3:0] ST_TX_LO    = 4'd5;
  localparam logic [3:0] ST_ACK_SET  = 4'd6;
  localparam logic [3:0] ST_ACK_POLL = 4'd7;
  localparam logic [3:0] ST_RS_LO    = 4'd8;
  localparam logic [3:0] ST_RX_LO    = 4'd9;
  localparam logic [3:0] ST_RX_HI    = 4'd10;
  localparam logic [3:0] ST_MACK_LO  = 4'd11;
  localparam logic [3:0] ST_MACK_HI  = 4'd12;
  localparam logic [3:0] ST_STOP_LO  = 4'd13;
  localparam logic [3:0] ST_STOP_MID = 4'd14;
  localparam logic [3:0] ST_STOP_HI  = 4'd15;

  logic [3:0]  step_q, step_d;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  wait_q, wait_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] word_q, word_d;
  logic        two_q, two_d;
  logic [1:0]  left_q, left_d;
  logic        err_q, err_d;

  logic        out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;

  logic        fire, start;
  logic [3:0]  cur_step;
  logic [7:0]  cur_wait;
  logic [7:0]  full_dur, half_dur, dur, wait_inc;
  logic        ph_end;
  logic        scl, sdl, busy, done;
  logic [15:0] rdata;
  logic [7:0]  rx_shift;

  assign item_ready_o = !out_valid_q || m_ready_i;
  assign fire         = item_valid_i && item_ready_o;
  assign m_valid_o    = out_valid_q;
  assign m_data_o     = out_data_q;

  assign full_dur = (cfg_i.phase_ticks != 8'd0) ? cfg_i.phase_ticks : 8'd1;
  assign half_dur = (cfg_i.phase_ticks[7:1] != 7'd0) ? {1'b0, cfg_i.phase_ticks[7:1]} : 8'd1;

  assign start    = (step_q == ST_IDLE) &&
                    (item_i.cmd == CMD_READ1 || item_i.cmd == CMD_READ2);
  assign cur_step = start ? ST_START_HI : step_q;
  assign cur_wait = start ? 8'd0 : wait_q;
  assign wait_inc = cur_wait + 8'd1;
  assign dur      = (cur_step == ST_ACK_SET || cur_step == ST_RX_HI ||
                     cur_step == ST_STOP_MID) ? half_dur : full_dur;
  assign ph_end   = (wait_inc >= dur);
  assign rx_shift = (cur_wait == 8'd0) ? {shift_q[6:0], item_i.sda} : shift_q;

  always_comb begin
    step_d  = cur_step;
    bit_d   = start ? 3'd0 : bit_q;
    wait_d  = cur_wait;
    shift_d = shift_q;
    word_d  = start ? {8'd0, item_i.reg_addr} : word_q;
    two_d   = start ? (item_i.cmd == CMD_READ2) : two_q;
    left_d  = start ? 2'd0 : left_q;
    err_d   = start ? 1'b0 : err_q;
    scl     = 1'b1;
    sdl     = 1'b0;
    done    = 1'b0;
    rdata   = 16'd0;
    busy    = (cur_step != ST_IDLE);

    // phased states count up and wrap to zero at phase end
    if (cur_step != ST_IDLE && cur_step != ST_ACK_POLL) begin
      wait_d = ph_end ? 8'd0 : wait_inc;
    end

    unique case (cur_step)
      ST_IDLE: begin
      end
      ST_START_HI: begin
        if (ph_end) step_d = ST_START_LO;
      end
      ST_START_LO: begin
        sdl = 1'b1;
        if (ph_end) begin
          shift_d = {cfg_i.dev_addr, (left_d >= 2'd2)};
          bit_d   = 3'd0;
          step_d  = ST_TX_SET;
        end
      end
      ST_TX_SET, ST_TX_HI, ST_TX_LO: begin
        sdl = ~shift_q[7];
        scl = (cur_step == ST_TX_HI);
        if (ph_end) begin
          if (cur_step == ST_TX_SET) begin
            step_d = ST_TX_HI;
          end else if (cur_step == ST_TX_HI) begin
            step_d = ST_TX_LO;
          end else begin
            shift_d = {shift_q[6:0], 1'b0};
            if (bit_d == 3'd7) begin
              bit_d  = 3'd0;
              step_d = ST_ACK_SET;
            end else begin
              bit_d  = bit_d + 3'd1;
              step_d = ST_TX_SET;
            end
          end
        end
      end
      ST_ACK_SET: begin
        if (ph_end) step_d = ST_ACK_POLL;
      end
      ST_ACK_POLL: begin
        if (!item_i.sda) begin
          wait_d = 8'd0;
          priority case (left_d)
            2'd0: begin
              left_d  = 2'd1;
              shift_d = word_d[7:0];
              bit_d   = 3'd0;
              step_d  = ST_TX_SET;
            end
            2'd1: begin
              left_d = 2'd2;
              step_d = ST_RS_LO;
            end
            default: begin
              left_d = two_d ? 2'd2 : 2'd1;
              word_d = 16'd0;
              bit_d  = 3'd0;
              step_d = ST_RX_LO;
            end
          endcase
        end else if (cur_wait >= cfg_i.ack_timeout) begin
          // missing acknowledge: abort through a stop
          wait_d = 8'd0;
          err_d  = 1'b1;
          step_d = ST_STOP_LO;
        end else begin
          wait_d = wait_inc;
        end
      end
      ST_RS_LO: begin
        scl = 1'b0;
        if (ph_end) step_d = ST_START_HI;
      end
      ST_RX_LO: begin
        scl = 1'b0;
        if (ph_end) step_d = ST_RX_HI;
      end
      ST_RX_HI: begin
        shift_d = rx_shift;
        if (ph_end) begin
          if (bit_d == 3'd7) begin
            bit_d  = 3'd0;
            word_d = {word_d[7:0], rx_shift};
            if (left_d != 2'd0) left_d = left_d - 2'd1;
            step_d = ST_MACK_LO;
          end else begin
            bit_d  = bit_d + 3'd1;
            step_d = ST_RX_LO;
          end
        end
      end
      ST_MACK_LO, ST_MACK_HI: begin
        sdl = (left_d != 2'd0);
        scl = (cur_step == ST_MACK_HI);
        if (ph_end) begin
          if (cur_step == ST_MACK_LO) step_d = ST_MACK_HI;
          else step_d = (left_d != 2'd0) ? ST_RX_LO : ST_STOP_LO;
        end
      end
      ST_STOP_LO: begin
        scl = 1'b0;
        sdl = 1'b1;
        if (ph_end) step_d = ST_STOP_MID;
      end
      ST_STOP_MID: begin
        sdl = 1'b1;
        if (ph_end) step_d = ST_STOP_HI;
      end
      ST_STOP_HI: begin
        if (ph_end) begin
          done   = 1'b1;
          rdata  = err_d ? 16'd0 : word_d;
          step_d = ST_IDLE;
        end
      end
      default: begin
        step_d = ST_IDLE;
        wait_d = 8'd0;
        busy   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      bit_q       <= 3'd0;
      wait_q      <= 8'd0;
      shift_q     <= 8'd0;
      word_q      <= 16'd0;
      two_q       <= 1'b0;
      left_q      <= 2'd0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        step_q  <= step_d;
        bit_q   <= bit_d;
        wait_q  <= wait_d;
        shift_q <= shift_d;
        word_q  <= word_d;
        two_q   <= two_d;
        left_q  <= left_d;
        err_q   <= err_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {3'd0, rdata, err_d, done, busy, sdl, scl};
    end
  end

endmodule
`default_nettype wire

@@ hdl/i2c_master_register_read.sv @@
// top level of the bit-banged i2c master that reads one or two register bytes
//
// usage:
//   every request on the slave stream is one bus tick: tuser carries the command
//   (0 tick only, 1 start a one-byte read, 2 start a two-byte read, 3 acts as
//   tick), tdata carries the register address and the sampled sda level
//   every request yields exactly one result on the master stream with the pin
//   levels to drive (scl, sda_low), busy, a one-tick done pulse, the error flag
//   and the read data (valid on the done tick only)
//   a request passes through the queue entry and then the result register;
//   throughput is one request per cycle while the receiver does not stall
//   a two-entry queue separates request decode from the sequencer, and the
//   result register lets a new request enter while a result waits
//   when the receiver stalls the result holds, the queue fills and tready drops
//   reset empties the queue and the result register, puts the sequencer in idle
//   and loads the configuration defaults (address 0x36, phase 20, timeout 250)
//   configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i and
//   takes effect at once; write it only while the block is idle
`default_nettype none
module i2c_master_register_read (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // configuration write port
  input  wire                                  cfg_we_i,
  input  wire  [i2cmrr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [i2cmrr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // request stream
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [i2cmrr_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // reg_addr[7:0], sda_in[8], zero
  input  wire  [i2cmrr_pkg::S_TUSER_W-1:0]     s_axis_tuser,  // func[1:0]
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // scl[0], sda_low[1], busy_res[2], done_res[3], ack_error[4], read_data[20:5], zero
  output logic [i2cmrr_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
  import i2cmrr_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  logic  item_valid, item_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr    <= DEV_ADDR_RST;
      cfg_q.phase_ticks <= PHASE_TICKS_RST;
      cfg_q.ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEV_ADDR:    cfg_q.dev_addr    <= cfg_data_i[6:0];
        CFG_PHASE_TICKS: cfg_q.phase_ticks <= cfg_data_i;
        CFG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // request decode and queue
  i2cmrr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // bus sequencer and result register
  i2cmrr_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .cfg_i        (cfg_q),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (m_axis_tdata)
  );

endmodule
`default_nettype wire

@@ hdl/i2cmrr_checker.sv @@
// port-level checks of the i2c register-read master, bound to the top level
`default_nettype none
module i2cmrr_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                s_axis_tready,
  input wire                                m_axis_tvalid,
  input wire                                m_axis_tready,
  input wire [i2cmrr_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  // a stalled result stays and holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // the request side only backs up behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("request side stalled with no result pending");

  // done is only reported by a busy sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2])
    else $error("done without busy");

  // read data shows only on a clean done tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (!m_axis_tdata[3] || m_axis_tdata[4]) |-> m_axis_tdata[20:5] == 16'd0)
    else $error("read data outside a clean done tick");

endmodule

bind i2c_master_register_read i2cmrr_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
